[src/ppj_pkg.sv]
// shared types and constants for the vertex perspective projection block
package ppj_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_COS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_SIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y   = 3'd6;

    localparam logic [17:0] PITCH_COS_RST = 18'h10000;

    typedef struct packed {
        logic signed [15:0] model_x;
        logic signed [15:0] model_y;
        logic signed [15:0] model_z;
        logic signed [31:0] place_x;
        logic signed [31:0] place_y;
        logic signed [31:0] place_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic signed [31:0] view_depth;
    } t_out_item;

    // values that ride along with the reciprocal divider
    typedef struct packed {
        logic signed [31:0] mx;
        logic signed [31:0] nry;
        logic signed [31:0] rz;
    } t_div_side;

endpackage

[src/ppj_div.sv]
// pipelined restoring divider for fov over clamped depth, one quotient bit per stage
module ppj_div
    import ppj_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned FOV       = 300
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_div_side i_side,
    output logic      o_valid,
    input  logic      i_ready,
    output t_div_side o_side,
    output logic [31:0] o_scale
);

    localparam int unsigned NUM_W = $clog2(FOV + 1) + 2 * FRAC_BITS;
    localparam int unsigned QW    = NUM_W - FRAC_BITS;
    localparam int unsigned QWX   = (QW > 32) ? QW : 32;
    localparam logic [63:0] NUM   = 64'(FOV) << (2 * FRAC_BITS);
    localparam logic [31:0] REM0  = 32'(NUM >> QW);
    localparam logic [31:0] ONE   = 32'(1) << FRAC_BITS;

    logic            r_vld  [QW];
    logic [31:0]     r_rem  [QW];
    logic [31:0]     r_d    [QW];
    logic [QWX-1:0]  r_q    [QW];
    t_div_side       r_side [QW];
    logic [QW:0]     en;

    assign en[QW] = i_ready;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [31:0]    rem_in;
        logic [31:0]    d_in;
        logic [QWX-1:0] q_in;
        t_div_side      side_in;
        logic           vld_in;
        logic [32:0]    trial;
        logic [32:0]    diff;

        if (k == 0) begin : g_first
            assign rem_in  = REM0;
            assign q_in    = '0;
            assign side_in = i_side;
            assign vld_in  = i_valid;
            // depth below one is clamped to one
            assign d_in    = (i_side.rz < $signed(ONE)) ? ONE : i_side.rz;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
            assign vld_in  = r_vld[k-1];
            assign d_in    = r_d[k-1];
        end

        assign en[k] = !r_vld[k] || en[k+1];
        assign trial = {rem_in, NUM[QW-1-k]};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en[k]) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k]) begin
                r_rem[k]  <= diff[32] ? trial[31:0] : diff[31:0];
                r_q[k]    <= {q_in[QWX-2:0], !diff[32]};
                r_d[k]    <= d_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[QW-1];
    assign o_side  = r_side[QW-1];
    assign o_scale = r_q[QW-1][31:0];

endmodule

[src/vertex_perspective_project_top.sv]
// top level of the vertex perspective projection pipeline
// Takes one vertex per clock while o_in_ready is high and returns one projected point
// per vertex, in order. The depth divider yields one quotient bit per stage. Front
// stages translate, multiply by the pitch terms and rotate; back stages scale by the
// reciprocal and add the screen center and pixel shift. Each stage holds its data while
// the next one is full, so a stalled output only backs up the pipe as far as it is
// occupied.
module vertex_perspective_project_top
    import ppj_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16,
    parameter int unsigned SCREEN_W  = 396,
    parameter int unsigned SCREEN_H  = 224,
    parameter int unsigned FOV       = 300
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [31:0] CX_FX = 32'(SCREEN_W / 2) << FRAC_BITS;
    localparam logic [31:0] CY_FX = 32'(SCREEN_H / 2) << FRAC_BITS;

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[FRAC_BITS+31:FRAC_BITS];
    endfunction

    // configuration registers
    logic signed [31:0] r_cam_x, r_cam_y, r_cam_z;
    logic signed [17:0] r_pitch_cos, r_pitch_sin;
    logic signed [10:0] r_shift_x, r_shift_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam_x     <= '0;
            r_cam_y     <= '0;
            r_cam_z     <= '0;
            r_pitch_cos <= PITCH_COS_RST;
            r_pitch_sin <= '0;
            r_shift_x   <= '0;
            r_shift_y   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CAM_POS_X: r_cam_x     <= i_cfg_data[31:0];
                CFG_CAM_POS_Y: r_cam_y     <= i_cfg_data[31:0];
                CFG_CAM_POS_Z: r_cam_z     <= i_cfg_data[31:0];
                CFG_PITCH_COS: r_pitch_cos <= i_cfg_data[17:0];
                CFG_PITCH_SIN: r_pitch_sin <= i_cfg_data[17:0];
                CFG_SHIFT_X:   r_shift_x   <= i_cfg_data[10:0];
                CFG_SHIFT_Y:   r_shift_y   <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // stage valid bits and load enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;
    logic div_in_rdy, div_out_vld;

    assign en5 = !r_v5 || i_out_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || div_in_rdy;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= div_out_vld;
            if (en5) r_v5 <= r_v4;
        end
    end

    // stage 1: fixed point, world offset, camera
    logic signed [31:0] r1_mx, r1_my, r1_mz;
    logic signed [31:0] n1_mx, n1_my, n1_mz;

    assign n1_mx = (32'(i_in_data.model_x) << FRAC_BITS) + i_in_data.place_x - r_cam_x;
    assign n1_my = (32'(i_in_data.model_y) << FRAC_BITS) + i_in_data.place_y - r_cam_y;
    assign n1_mz = (32'(i_in_data.model_z) << FRAC_BITS) + i_in_data.place_z - r_cam_z;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_mx <= n1_mx;
            r1_my <= n1_my;
            r1_mz <= n1_mz;
        end
    end

    // stage 2: pitch products
    logic signed [31:0] r2_mx, r2_yc, r2_zs, r2_ys, r2_zc;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_mx <= r1_mx;
            r2_yc <= fx_mul(r1_my, 32'(r_pitch_cos));
            r2_zs <= fx_mul(r1_mz, 32'(r_pitch_sin));
            r2_ys <= fx_mul(r1_my, 32'(r_pitch_sin));
            r2_zc <= fx_mul(r1_mz, 32'(r_pitch_cos));
        end
    end

    // stage 3: rotation, y kept negated for the screen flip
    t_div_side r3_side;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_side.mx  <= r2_mx;
            r3_side.nry <= r2_zs - r2_yc;
            r3_side.rz  <= r2_ys + r2_zc;
        end
    end

    // reciprocal of depth
    t_div_side   div_side;
    logic [31:0] div_scale;

    ppj_div #(
        .FRAC_BITS (FRAC_BITS),
        .FOV       (FOV)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v3),
        .o_ready (div_in_rdy),
        .i_side  (r3_side),
        .o_valid (div_out_vld),
        .i_ready (en4),
        .o_side  (div_side),
        .o_scale (div_scale)
    );

    // stage 4: perspective scale
    logic signed [31:0] r4_px, r4_py, r4_rz;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_px <= fx_mul(div_side.mx, div_scale);
            r4_py <= fx_mul(div_side.nry, div_scale);
            r4_rz <= div_side.rz;
        end
    end

    // stage 5: screen center and pixel shift
    t_out_item   r5_out;
    logic [31:0] shx_fx, shy_fx;

    assign shx_fx = 32'(r_shift_x) << FRAC_BITS;
    assign shy_fx = 32'(r_shift_y) << FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_out.screen_x   <= r4_px + CX_FX + shx_fx;
            r5_out.screen_y   <= r4_py + CY_FX + shy_fx;
            r5_out.view_depth <= r4_rz;
        end
    end

    assign o_in_ready  = en1;
    assign o_out_valid = r_v5;
    assign o_out_data  = r5_out;

endmodule
